// ===== hw/rtl/ttt_pkg.sv =====
// Shared types and codes for the transaction timeout table.
`timescale 1ns / 1ps

package ttt_pkg;

  localparam int SLOT_W = 6;
  localparam logic [15:0] TIMEOUT_RESET = 16'd2000;

  typedef enum logic [2:0] {
    CMD_CREATE   = 3'd0,
    CMD_DESTROY  = 3'd1,
    CMD_BIND     = 3'd2,
    CMD_FIND_REQ = 3'd3,
    CMD_FIND_SID = 3'd4,
    CMD_ADVANCE  = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_INVALID   = 3'd3,
    ST_EXPIRED   = 3'd4,
    ST_NONE      = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FIN,
    S_EMIT
  } state_t;

  // Search key carried with one command.
  typedef struct packed {
    logic [63:0] peer_fseid;
    logic [31:0] sequence_req;
    logic [63:0] session_id;
  } key_t;

  // Contents of one slot as seen by the compare unit.
  typedef struct packed {
    logic        used;
    logic        expired;
    logic        keyed;
    logic [63:0] deadline;
    logic [63:0] session;
    logic [63:0] peer_fseid;
    logic [31:0] sequence_req;
  } slot_rec_t;

endpackage

// ===== hw/rtl/ttt_slot_match.sv =====
// Per-slot compare unit shared by create, both finds and advance.
`timescale 1ns / 1ps

module ttt_slot_match (
  input  ttt_pkg::cmd_t      cmd,
  input  ttt_pkg::key_t      key,
  input  logic [63:0]        clock_ms,
  input  ttt_pkg::slot_rec_t rec,
  output logic               hit
);

  always_comb begin
    case (cmd)
      ttt_pkg::CMD_CREATE:   hit = !rec.used;
      ttt_pkg::CMD_FIND_REQ: hit = rec.used && rec.keyed &&
                                   (rec.peer_fseid == key.peer_fseid) &&
                                   (rec.sequence_req == key.sequence_req);
      ttt_pkg::CMD_FIND_SID: hit = rec.used && (rec.session == key.session_id);
      ttt_pkg::CMD_ADVANCE:  hit = rec.used && !rec.expired &&
                                   (rec.deadline <= clock_ms);
      default:               hit = 1'b0;
    endcase
  end

endmodule

// ===== hw/rtl/transaction_timeout_table_unit.sv =====
// Top level of the transaction timeout table: sequencer, slot storage and result register.
`timescale 1ns / 1ps

// Slot table of pending transactions with one hard timeout. Destroy and bind go from
// accept straight to the finish state, which loads the result register. Create and
// both finds walk every slot through the single compare unit, one slot per cycle at
// the rate of the slot memory read port, then load their result. Advance does the
// same walk, marking expired slots, then sends one word per expired slot, stepping
// one slot index per cycle up to the highest expired slot, holding at an expired
// slot while the output register is full. A single "none expired" word ends an
// advance that expires nothing. The input is not ready while a command is in
// progress; a finished word waits in the output register while the next command is
// accepted. Unused command codes are accepted and dropped.
module transaction_timeout_table_unit #(
  parameter int SLOTS = 64
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [5:0]  in_slot_index,
  input  logic [63:0] in_peer_fseid,
  input  logic [31:0] in_sequence_req,
  input  logic [63:0] in_session_id,
  input  logic        in_has_request,
  input  logic [31:0] in_advance_ms,

  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [5:0]  out_result_slot,
  output logic        out_last,

  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  localparam int SW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  ttt_pkg::state_t state_r, state_nxt;
  ttt_pkg::cmd_t   cmd_r;
  ttt_pkg::key_t   key_r;
  logic [5:0]      idx_r;
  logic            has_req_r;

  logic [15:0]     timeout_r;
  logic [63:0]     clock_r;

  logic [SLOTS-1:0] used_r;
  logic [SLOTS-1:0] expired_r;
  logic [SLOTS-1:0] keyed_r;
  logic [SLOTS-1:0] hit_vec_r;

  logic [CW-1:0]   cnt_r;
  logic            ev_valid_r;
  logic [SW-1:0]   ev_idx_r;
  logic            found_r;
  logic [SW-1:0]   first_r;

  logic [63:0] deadline_mem [SLOTS];
  logic [63:0] session_mem  [SLOTS];
  logic [63:0] fseid_mem    [SLOTS];
  logic [31:0] seq_mem      [SLOTS];

  logic [63:0] rd_deadline_r;
  logic [63:0] rd_session_r;
  logic [63:0] rd_fseid_r;
  logic [31:0] rd_seq_r;

  logic        out_valid_r;
  ttt_pkg::status_t out_status_r;
  logic [5:0]  out_slot_r;
  logic        out_last_r;

  ttt_pkg::slot_rec_t ev_rec;
  logic        ev_hit;
  logic        in_acc;
  logic        out_free;
  logic        scan_more;
  logic        idx_ok;
  logic [SW-1:0] emit_idx;
  logic [SLOTS-1:0] emit_rest;

  // Sequencer outputs
  logic             out_load;
  ttt_pkg::status_t ld_status;
  logic [5:0]       ld_slot;
  logic             ld_last;
  logic             dl_we;
  logic             sess_we;
  logic             key_we;
  logic             keyed_we;
  logic             keyed_val;
  logic             used_set;
  logic             used_clr;
  logic             hit_clr;
  logic             cnt_step;
  logic [SW-1:0]    wr_addr;
  logic [63:0]      wr_session;
  logic [63:0]      wr_fseid;
  logic [31:0]      wr_seq;

  assign in_ready  = (state_r == ttt_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign scan_more = (cnt_r < CW'(SLOTS));
  assign idx_ok    = ({1'b0, idx_r} < 7'(SLOTS)) && used_r[idx_r[SW-1:0]];
  assign emit_idx  = cnt_r[SW-1:0];
  assign emit_rest = hit_vec_r & ~(SLOTS'(1) << emit_idx);

  assign ev_rec.used         = used_r[ev_idx_r];
  assign ev_rec.expired      = expired_r[ev_idx_r];
  assign ev_rec.keyed        = keyed_r[ev_idx_r];
  assign ev_rec.deadline     = rd_deadline_r;
  assign ev_rec.session      = rd_session_r;
  assign ev_rec.peer_fseid   = rd_fseid_r;
  assign ev_rec.sequence_req = rd_seq_r;

  ttt_slot_match u_match (
    .cmd      (cmd_r),
    .key      (key_r),
    .clock_ms (clock_r),
    .rec      (ev_rec),
    .hit      (ev_hit)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ttt_pkg::S_IDLE: begin
        if (in_valid) begin
          case (ttt_pkg::cmd_t'(in_command))
            ttt_pkg::CMD_CREATE,
            ttt_pkg::CMD_FIND_REQ,
            ttt_pkg::CMD_FIND_SID,
            ttt_pkg::CMD_ADVANCE: state_nxt = ttt_pkg::S_SCAN;
            ttt_pkg::CMD_DESTROY,
            ttt_pkg::CMD_BIND:    state_nxt = ttt_pkg::S_FIN;
            default:              state_nxt = ttt_pkg::S_IDLE;
          endcase
        end
      end
      ttt_pkg::S_SCAN: begin
        if (!scan_more && !ev_valid_r) begin
          state_nxt = ttt_pkg::S_FIN;
        end
      end
      ttt_pkg::S_FIN: begin
        if (cmd_r == ttt_pkg::CMD_ADVANCE && hit_vec_r != '0) begin
          state_nxt = ttt_pkg::S_EMIT;
        end else if (out_free) begin
          state_nxt = ttt_pkg::S_IDLE;
        end
      end
      ttt_pkg::S_EMIT: begin
        if (out_load && ld_last) begin
          state_nxt = ttt_pkg::S_IDLE;
        end
      end
      default: state_nxt = ttt_pkg::S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    out_load   = 1'b0;
    ld_status  = ttt_pkg::ST_OK;
    ld_slot    = '0;
    ld_last    = 1'b1;
    dl_we      = 1'b0;
    sess_we    = 1'b0;
    key_we     = 1'b0;
    keyed_we   = 1'b0;
    keyed_val  = 1'b0;
    used_set   = 1'b0;
    used_clr   = 1'b0;
    hit_clr    = 1'b0;
    cnt_step   = 1'b0;
    wr_addr    = first_r;
    wr_session = '0;
    wr_fseid   = '0;
    wr_seq     = '0;
    case (state_r)
      ttt_pkg::S_FIN: begin
        if (out_free) begin
          case (cmd_r)
            ttt_pkg::CMD_CREATE: begin
              out_load = 1'b1;
              if (found_r) begin
                ld_slot  = 6'(first_r);
                dl_we    = 1'b1;
                sess_we  = 1'b1;
                key_we   = 1'b1;
                keyed_we = 1'b1;
                used_set = 1'b1;
              end else begin
                ld_status = ttt_pkg::ST_FULL;
              end
            end
            ttt_pkg::CMD_DESTROY: begin
              out_load = 1'b1;
              ld_slot  = idx_r;
              if (idx_ok) begin
                used_clr = 1'b1;
              end else begin
                ld_status = ttt_pkg::ST_INVALID;
              end
            end
            ttt_pkg::CMD_BIND: begin
              out_load   = 1'b1;
              ld_slot    = idx_r;
              wr_addr    = idx_r[SW-1:0];
              wr_session = key_r.session_id;
              wr_fseid   = key_r.peer_fseid;
              wr_seq     = key_r.sequence_req;
              keyed_val  = has_req_r;
              if (idx_ok) begin
                sess_we  = 1'b1;
                key_we   = has_req_r;
                keyed_we = 1'b1;
              end else begin
                ld_status = ttt_pkg::ST_INVALID;
              end
            end
            ttt_pkg::CMD_FIND_REQ,
            ttt_pkg::CMD_FIND_SID: begin
              out_load = 1'b1;
              if (found_r) begin
                ld_slot = 6'(first_r);
              end else begin
                ld_status = ttt_pkg::ST_NOT_FOUND;
              end
            end
            ttt_pkg::CMD_ADVANCE: begin
              if (hit_vec_r == '0) begin
                out_load  = 1'b1;
                ld_status = ttt_pkg::ST_NONE;
              end
            end
            default: out_load = 1'b0;
          endcase
        end
      end
      ttt_pkg::S_EMIT: begin
        if (!hit_vec_r[emit_idx]) begin
          cnt_step = 1'b1;
        end else if (out_free) begin
          out_load  = 1'b1;
          ld_status = ttt_pkg::ST_EXPIRED;
          ld_slot   = 6'(emit_idx);
          ld_last   = (emit_rest == '0);
          hit_clr   = 1'b1;
          cnt_step  = 1'b1;
        end
      end
      default: out_load = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ttt_pkg::S_IDLE;
      timeout_r   <= ttt_pkg::TIMEOUT_RESET;
      clock_r     <= '0;
      used_r      <= '0;
      expired_r   <= '0;
      hit_vec_r   <= '0;
      cnt_r       <= '0;
      ev_valid_r  <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
      if (in_acc && ttt_pkg::cmd_t'(in_command) == ttt_pkg::CMD_ADVANCE) begin
        clock_r <= clock_r + 64'(in_advance_ms);
      end
      ev_valid_r <= (state_r == ttt_pkg::S_SCAN) && scan_more;
      if (in_acc) begin
        cnt_r     <= '0;
        found_r   <= 1'b0;
        hit_vec_r <= '0;
      end else if (state_r == ttt_pkg::S_SCAN) begin
        if (scan_more) begin
          cnt_r <= cnt_r + CW'(1);
        end
        if (ev_valid_r && ev_hit) begin
          hit_vec_r[ev_idx_r] <= 1'b1;
          if (!found_r) begin
            found_r <= 1'b1;
          end
          if (cmd_r == ttt_pkg::CMD_ADVANCE) begin
            expired_r[ev_idx_r] <= 1'b1;
          end
        end
      end else if (state_r == ttt_pkg::S_FIN) begin
        // restart the counter for the emit walk
        cnt_r <= '0;
      end else if (cnt_step) begin
        cnt_r <= cnt_r + CW'(1);
      end
      if (hit_clr) begin
        hit_vec_r[emit_idx] <= 1'b0;
      end
      if (used_set) begin
        used_r[wr_addr]    <= 1'b1;
        expired_r[wr_addr] <= 1'b0;
      end
      if (used_clr) begin
        used_r[idx_r[SW-1:0]]    <= 1'b0;
        expired_r[idx_r[SW-1:0]] <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cmd_r                <= ttt_pkg::cmd_t'(in_command);
      idx_r                <= in_slot_index;
      has_req_r            <= in_has_request;
      key_r.peer_fseid     <= in_peer_fseid;
      key_r.sequence_req   <= in_sequence_req;
      key_r.session_id     <= in_session_id;
    end
    ev_idx_r <= cnt_r[SW-1:0];
    if (state_r == ttt_pkg::S_SCAN && ev_valid_r && ev_hit && !found_r) begin
      first_r <= ev_idx_r;
    end
    if (keyed_we) begin
      keyed_r[wr_addr] <= keyed_val;
    end
    if (out_load) begin
      out_status_r <= ld_status;
      out_slot_r   <= ld_slot;
      out_last_r   <= ld_last;
    end
  end

  // Slot memories: one write port, one registered read port each
  always_ff @(posedge clk) begin
    if (dl_we) begin
      deadline_mem[wr_addr] <= clock_r + 64'(timeout_r);
    end
    if (sess_we) begin
      session_mem[wr_addr] <= wr_session;
    end
    if (key_we) begin
      fseid_mem[wr_addr] <= wr_fseid;
      seq_mem[wr_addr]   <= wr_seq;
    end
    rd_deadline_r <= deadline_mem[cnt_r[SW-1:0]];
    rd_session_r  <= session_mem[cnt_r[SW-1:0]];
    rd_fseid_r    <= fseid_mem[cnt_r[SW-1:0]];
    rd_seq_r      <= seq_mem[cnt_r[SW-1:0]];
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_result_slot = out_slot_r;
  assign out_last        = out_last_r;

`ifndef SYNTH
  a_expired_only_used: assert property (@(posedge clk) disable iff (!rst_n)
    (expired_r & ~used_r) == '0)
    else $error("expired flag set on a free slot");

  a_eval_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> state_r == ttt_pkg::S_SCAN)
    else $error("slot compare pending outside the scan");

  a_emit_has_hits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ttt_pkg::S_EMIT |-> hit_vec_r != '0)
    else $error("emit walk running with no expired slot left");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> !$past(out_load))
    else $error("result word overwritten before it was taken");
`endif

endmodule

// ===== tb/sv/transaction_timeout_table_unit_tb.sv =====
// Self-checking testbench for the transaction timeout table: directed table, then random.
`timescale 1ns / 1ps

module transaction_timeout_table_unit_tb;

  localparam int TABLE_SLOTS = 64;
  // Longest walk plus the widest advance burst, with margin.
  localparam int DRAIN_CYCLES = 2 * TABLE_SLOTS + 24;
  localparam logic [2:0] CMD_SPARE6 = 3'd6;
  localparam logic [2:0] CMD_SPARE7 = 3'd7;
  localparam logic [63:0] ONES64 = '1;
  localparam logic [31:0] ONES32 = '1;

  typedef struct packed {
    ttt_pkg::status_t status;
    logic [5:0]       slot;
    logic             last;
  } reply_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [5:0]       slot;
    logic [63:0]      fseid;
    logic [31:0]      seq;
    logic [63:0]      sid;
    logic             has_req;
    logic [31:0]      adv;
    logic             typed;
    ttt_pkg::status_t exp_status;
    logic [5:0]       exp_slot;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_command = '0;
  logic [5:0]  in_slot_index = '0;
  logic [63:0] in_peer_fseid = '0;
  logic [31:0] in_sequence_req = '0;
  logic [63:0] in_session_id = '0;
  logic        in_has_request = 1'b0;
  logic [31:0] in_advance_ms = '0;
  logic        out_valid;
  logic        out_ready = 1'b1;
  logic [2:0]  out_status;
  logic [5:0]  out_result_slot;
  logic        out_last;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;

  // Shadow copy of the table.
  logic [15:0] tbl_timeout;
  logic [63:0] tbl_clock;
  logic        tbl_used    [TABLE_SLOTS];
  logic        tbl_expired [TABLE_SLOTS];
  logic [63:0] tbl_deadline[TABLE_SLOTS];
  logic [63:0] tbl_session [TABLE_SLOTS];
  logic [63:0] tbl_fseid   [TABLE_SLOTS];
  logic [31:0] tbl_seq     [TABLE_SLOTS];
  logic        tbl_keyed   [TABLE_SLOTS];

  reply_t   step_replies[$];
  reply_t   expected_replies[$];
  dir_row_t dir_rows[$];
  reply_t   mon_want;
  int       fail_count = 0;
  bit       quiet = 1'b0;
  int       idle_rate = 10;
  int       stall_left = 0;
  int       mode_cycles = 0;

  transaction_timeout_table_unit #(
    .SLOTS(TABLE_SLOTS)
  ) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_command(in_command),
    .in_slot_index(in_slot_index),
    .in_peer_fseid(in_peer_fseid),
    .in_sequence_req(in_sequence_req),
    .in_session_id(in_session_id),
    .in_has_request(in_has_request),
    .in_advance_ms(in_advance_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_status(out_status),
    .out_result_slot(out_result_slot),
    .out_last(out_last),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  function automatic reply_t reply(ttt_pkg::status_t s, logic [5:0] sl, logic l);
    reply_t r;
    r.status = s;
    r.slot = sl;
    r.last = l;
    return r;
  endfunction

  // Work out the words one command produces and update the shadow table.
  task automatic predict_table_response(input logic [2:0] cmd, input logic [5:0] slot,
                                        input logic [63:0] fseid, input logic [31:0] seq,
                                        input logic [63:0] sid, input logic has_req,
                                        input logic [31:0] adv);
    int hit;
    int top;
    step_replies.delete();
    hit = -1;
    top = -1;
    case (cmd)
      ttt_pkg::CMD_CREATE: begin
        for (int i = TABLE_SLOTS - 1; i >= 0; i--) if (!tbl_used[i]) hit = i;
        if (hit < 0) begin
          step_replies.push_back(reply(ttt_pkg::ST_FULL, 6'd0, 1'b1));
        end else begin
          tbl_used[hit] = 1'b1;
          tbl_expired[hit] = 1'b0;
          tbl_deadline[hit] = tbl_clock + {48'd0, tbl_timeout};
          tbl_session[hit] = '0;
          tbl_fseid[hit] = '0;
          tbl_seq[hit] = '0;
          tbl_keyed[hit] = 1'b0;
          step_replies.push_back(reply(ttt_pkg::ST_OK, 6'(hit), 1'b1));
        end
      end
      ttt_pkg::CMD_DESTROY: begin
        if (!tbl_used[slot]) begin
          step_replies.push_back(reply(ttt_pkg::ST_INVALID, slot, 1'b1));
        end else begin
          tbl_used[slot] = 1'b0;
          tbl_expired[slot] = 1'b0;
          step_replies.push_back(reply(ttt_pkg::ST_OK, slot, 1'b1));
        end
      end
      ttt_pkg::CMD_BIND: begin
        if (!tbl_used[slot]) begin
          step_replies.push_back(reply(ttt_pkg::ST_INVALID, slot, 1'b1));
        end else begin
          tbl_session[slot] = sid;
          tbl_keyed[slot] = has_req;
          if (has_req) begin
            tbl_fseid[slot] = fseid;
            tbl_seq[slot] = seq;
          end
          step_replies.push_back(reply(ttt_pkg::ST_OK, slot, 1'b1));
        end
      end
      ttt_pkg::CMD_FIND_REQ: begin
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
          if (tbl_used[i] && tbl_keyed[i] && tbl_fseid[i] == fseid && tbl_seq[i] == seq)
            hit = i;
        if (hit < 0) step_replies.push_back(reply(ttt_pkg::ST_NOT_FOUND, 6'd0, 1'b1));
        else step_replies.push_back(reply(ttt_pkg::ST_OK, 6'(hit), 1'b1));
      end
      ttt_pkg::CMD_FIND_SID: begin
        for (int i = TABLE_SLOTS - 1; i >= 0; i--)
          if (tbl_used[i] && tbl_session[i] == sid) hit = i;
        if (hit < 0) step_replies.push_back(reply(ttt_pkg::ST_NOT_FOUND, 6'd0, 1'b1));
        else step_replies.push_back(reply(ttt_pkg::ST_OK, 6'(hit), 1'b1));
      end
      ttt_pkg::CMD_ADVANCE: begin
        tbl_clock = tbl_clock + {32'd0, adv};
        for (int i = 0; i < TABLE_SLOTS; i++)
          if (tbl_used[i] && !tbl_expired[i] && tbl_deadline[i] <= tbl_clock) top = i;
        if (top < 0) begin
          step_replies.push_back(reply(ttt_pkg::ST_NONE, 6'd0, 1'b1));
        end else begin
          for (int i = 0; i <= top; i++) begin
            if (tbl_used[i] && !tbl_expired[i] && tbl_deadline[i] <= tbl_clock) begin
              tbl_expired[i] = 1'b1;
              step_replies.push_back(reply(ttt_pkg::ST_EXPIRED, 6'(i), i == top));
            end
          end
        end
      end
      default: begin
        // spare codes are swallowed
      end
    endcase
  endtask

  // Drive one word, hold it until accepted, then queue what it should produce.
  task automatic send_word(input logic [2:0] cmd, input logic [5:0] slot,
                           input logic [63:0] fseid, input logic [31:0] seq,
                           input logic [63:0] sid, input logic has_req,
                           input logic [31:0] adv, input logic typed,
                           input ttt_pkg::status_t exp_status, input logic [5:0] exp_slot);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < idle_rate) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_command <= cmd;
    in_slot_index <= slot;
    in_peer_fseid <= fseid;
    in_sequence_req <= seq;
    in_session_id <= sid;
    in_has_request <= has_req;
    in_advance_ms <= adv;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_table_response(cmd, slot, fseid, seq, sid, has_req, adv);
    if (typed) expected_replies.push_back(reply(exp_status, exp_slot, 1'b1));
    else foreach (step_replies[k]) expected_replies.push_back(step_replies[k]);
  endtask

  task automatic add_row(input logic [2:0] cmd, input logic [5:0] slot,
                         input logic [63:0] fseid, input logic [31:0] seq,
                         input logic [63:0] sid, input logic has_req,
                         input logic [31:0] adv, input logic typed,
                         input ttt_pkg::status_t exp_status, input logic [5:0] exp_slot);
    dir_row_t r;
    r.cmd = cmd;
    r.slot = slot;
    r.fseid = fseid;
    r.seq = seq;
    r.sid = sid;
    r.has_req = has_req;
    r.adv = adv;
    r.typed = typed;
    r.exp_status = exp_status;
    r.exp_slot = exp_slot;
    dir_rows.push_back(r);
  endtask

  function automatic logic [5:0] pick_used_slot();
    logic [5:0] start;
    logic [5:0] probe;
    start = 6'($urandom_range(0, TABLE_SLOTS - 1));
    for (int k = 0; k < TABLE_SLOTS; k++) begin
      probe = start + 6'(k);
      if (tbl_used[probe]) return probe;
    end
    return start;
  endfunction

  function automatic int used_count();
    int n;
    n = 0;
    for (int i = 0; i < TABLE_SLOTS; i++) if (tbl_used[i]) n++;
    return n;
  endfunction

  // Half the keys come from a tiny pool so binds collide and finds hit.
  function automatic logic [63:0] rand_key64();
    if ($urandom_range(0, 1) != 0) return {$urandom, $urandom};
    return 64'($urandom_range(0, 3));
  endfunction

  task automatic send_random_word();
    logic [2:0]  cmd;
    logic [5:0]  slot;
    logic [5:0]  src;
    logic [63:0] fseid;
    logic [63:0] sid;
    logic [31:0] seq;
    logic [31:0] adv;
    logic        has_req;
    int          pick;
    slot = 6'($urandom_range(0, 63));
    fseid = rand_key64();
    sid = rand_key64();
    seq = ($urandom_range(0, 1) != 0) ? $urandom : 32'($urandom_range(0, 3));
    has_req = 1'($urandom_range(0, 1));
    adv = $urandom;
    pick = $urandom_range(0, 99);
    if (pick < 24) begin
      cmd = ttt_pkg::CMD_CREATE;
    end else if (pick < 38) begin
      cmd = ttt_pkg::CMD_DESTROY;
      if ($urandom_range(0, 4) != 0) slot = pick_used_slot();
    end else if (pick < 58) begin
      cmd = ttt_pkg::CMD_BIND;
      if ($urandom_range(0, 4) != 0) slot = pick_used_slot();
    end else if (pick < 70) begin
      cmd = ttt_pkg::CMD_FIND_REQ;
      if ($urandom_range(0, 2) != 0) begin
        src = pick_used_slot();
        fseid = tbl_fseid[src];
        seq = tbl_seq[src];
      end
    end else if (pick < 82) begin
      cmd = ttt_pkg::CMD_FIND_SID;
      if ($urandom_range(0, 2) != 0) sid = tbl_session[pick_used_slot()];
    end else if (pick < 98) begin
      cmd = ttt_pkg::CMD_ADVANCE;
      case ($urandom_range(0, 3))
        0: adv = '0;
        1: adv = 32'($urandom_range(0, int'(tbl_timeout)));
        2: adv = {16'd0, tbl_timeout};
        default: adv = $urandom;
      endcase
    end else begin
      cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE6 : CMD_SPARE7;
    end
    send_word(cmd, slot, fseid, seq, sid, has_req, adv, 1'b0, ttt_pkg::ST_OK, 6'd0);
  endtask

  task automatic run_phase(input int n_items, input bit do_fill);
    int fill_at;
    fill_at = do_fill ? $urandom_range(0, n_items - 1) : -1;
    for (int i = 0; i < n_items; i++) begin
      // fill the table and push past it
      if (i == fill_at) repeat (TABLE_SLOTS - used_count() + 2)
        send_word(ttt_pkg::CMD_CREATE, 6'($urandom), {$urandom, $urandom}, $urandom,
                  {$urandom, $urandom}, 1'($urandom), $urandom, 1'b0, ttt_pkg::ST_OK, 6'd0);
      send_random_word();
    end
  endtask

  task automatic write_timeout(input logic [15:0] value);
    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    tbl_timeout = value;
  endtask

  // Output stalls in bursts; the burst rate is reselected now and then.
  always @(posedge clk) begin
    mode_cycles++;
    if (mode_cycles >= 300) begin
      mode_cycles = 0;
      case ($urandom_range(0, 2))
        0: idle_rate = 0;
        1: idle_rate = 8;
        default: idle_rate = 30;
      endcase
    end
    if (stall_left != 0) stall_left--;
    else if (!quiet && $urandom_range(0, 99) < idle_rate / 2) stall_left = $urandom_range(1, 17);
    out_ready <= quiet || stall_left == 0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_replies.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected word status=%0d slot=%0d last=%0d", $time,
                 out_status, out_result_slot, out_last);
      end else begin
        mon_want = expected_replies.pop_front();
        if (out_status !== mon_want.status || out_result_slot !== mon_want.slot ||
            out_last !== mon_want.last) begin
          fail_count++;
          $display("%0t: expected status=%0d slot=%0d last=%0d,", $time,
                   mon_want.status, mon_want.slot, mon_want.last,
                   " got status=%0d slot=%0d last=%0d",
                   out_status, out_result_slot, out_last);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("** transaction_timeout_table_unit: FAILED **");
    $finish;
  end

  initial begin
    tbl_timeout = ttt_pkg::TIMEOUT_RESET;
    tbl_clock = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_expired[i] = 1'b0;
      tbl_deadline[i] = '0;
      tbl_session[i] = '0;
      tbl_fseid[i] = '0;
      tbl_seq[i] = '0;
      tbl_keyed[i] = 1'b0;
    end

    add_row(ttt_pkg::CMD_ADVANCE,  6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_NONE, 6'd0);
    add_row(ttt_pkg::CMD_FIND_SID, 6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_NOT_FOUND, 6'd0);
    add_row(ttt_pkg::CMD_FIND_REQ, 6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_NOT_FOUND, 6'd0);
    add_row(ttt_pkg::CMD_DESTROY,  6'd5,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_INVALID, 6'd5);
    add_row(ttt_pkg::CMD_BIND,     6'd63, ONES64, ONES32, ONES64, 1'b1, '0,       1'b1,
            ttt_pkg::ST_INVALID, 6'd63);
    add_row(ttt_pkg::CMD_CREATE,   6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_CREATE,   6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd1);
    // a fresh slot carries session zero
    add_row(ttt_pkg::CMD_FIND_SID, 6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_FIND_REQ, 6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_NOT_FOUND, 6'd0);
    add_row(ttt_pkg::CMD_BIND,     6'd0,  ONES64, ONES32, ONES64, 1'b1, ONES32,   1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_FIND_REQ, 6'd0,  ONES64, ONES32, '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_FIND_SID, 6'd0,  '0,     '0,     ONES64, 1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_BIND,     6'd1,  ONES64, ONES32, 64'd5,  1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd1);
    add_row(ttt_pkg::CMD_FIND_REQ, 6'd0,  ONES64, ONES32, '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_FIND_SID, 6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_NOT_FOUND, 6'd0);
    // unkeyed bind keeps the old key but it must not match
    add_row(ttt_pkg::CMD_BIND,     6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_FIND_REQ, 6'd0,  ONES64, ONES32, '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_NOT_FOUND, 6'd0);
    add_row(ttt_pkg::CMD_ADVANCE,  6'd0,  '0,     '0,     '0,     1'b0, 32'd1999, 1'b1,
            ttt_pkg::ST_NONE, 6'd0);
    add_row(ttt_pkg::CMD_ADVANCE,  6'd0,  '0,     '0,     '0,     1'b0, 32'd1,    1'b0,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_ADVANCE,  6'd0,  '0,     '0,     '0,     1'b0, ONES32,   1'b1,
            ttt_pkg::ST_NONE, 6'd0);
    add_row(CMD_SPARE6,            6'd0,  ONES64, ONES32, ONES64, 1'b1, ONES32,   1'b0,
            ttt_pkg::ST_OK, 6'd0);
    add_row(CMD_SPARE7,            6'd63, '0,     '0,     '0,     1'b0, '0,       1'b0,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_DESTROY,  6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_DESTROY,  6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_INVALID, 6'd0);
    add_row(ttt_pkg::CMD_CREATE,   6'd0,  '0,     '0,     '0,     1'b0, '0,       1'b1,
            ttt_pkg::ST_OK, 6'd0);
    add_row(ttt_pkg::CMD_ADVANCE,  6'd0,  '0,     '0,     '0,     1'b0, ONES32,   1'b0,
            ttt_pkg::ST_OK, 6'd0);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r])
      send_word(dir_rows[r].cmd, dir_rows[r].slot, dir_rows[r].fseid, dir_rows[r].seq,
                dir_rows[r].sid, dir_rows[r].has_req, dir_rows[r].adv, dir_rows[r].typed,
                dir_rows[r].exp_status, dir_rows[r].exp_slot);

    run_phase(40, 1'b0);
    write_timeout(16'd1);
    run_phase(40, 1'b0);
    write_timeout(16'd65535);
    run_phase(40, 1'b1);
    write_timeout(16'($urandom_range(1, 65535)));
    run_phase(40, 1'b0);
    quiet = 1'b1;
    write_timeout(ttt_pkg::TIMEOUT_RESET);
    run_phase(40, 1'b1);

    in_valid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("** transaction_timeout_table_unit: PASSED **");
    end else begin
      $display("** transaction_timeout_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
